[hdl/csv_field_tokenizer_unit_macros.svh]
// Assertion macros shared by the CSV tokenizer RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef CSV_FIELD_TOKENIZER_UNIT_MACROS_SVH
`define CSV_FIELD_TOKENIZER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define CSVT_ASSERT_IMP(label, clk_sig, rst_sig, ante, cons, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define CSVT_ASSERT_NXT(label, clk_sig, rst_sig, ante, cons, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/csvt_pkg.sv]
// Shared types and constants for the CSV field tokenizer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package csvt_pkg;

  // Result kinds
  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_FIELD = 2'd1;
  localparam logic [1:0] KIND_ROW   = 2'd2;

  // Byte values with a fixed meaning
  localparam logic [7:0] CHAR_QUOTE = 8'h22;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_DELIMITER  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SKIP_BLANK = 1'b1;

  // Entries in the queue between the front and back parts
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_data;
  } text_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic       trim_overflow;
    logic       last;
  } token_item_t;

  // One classified text byte: which sub-actions it needs and its class flags.
  typedef struct packed {
    logic       take_cr;
    logic       take_byte;
    logic       close_line;
    logic [7:0] data;
    logic       is_space;
    logic       is_delim;
    logic       is_quote;
    logic       cr_is_delim;
  } step_t;

endpackage

[hdl/csv_field_tokenizer_unit.sv]
// Channel  Handshake            Beat payload
// text     text_valid/stall     text_item_t: in_byte, end_of_data
// token    token_valid/stall    token_item_t: kind, out_byte, trim_overflow, last
// cfg      cfg_valid/ready      cfg_index, cfg_data (0 delimiter, 1 skip_blank_lines)
//
// The front takes one text beat per cycle while its two-entry queue has room.
// The back emits at most one result per cycle: a byte ending held whitespace
// first sends the held bytes, and a line end or a character after a closing
// quote may be looked at again before its step ends.
// Reset is synchronous; it clears parser state and the queue but not the
// contents of the trim store. token_stall holds the output register and one
// further result in the hold stage; text_stall rises only when the queue fills.
// Top level of the CSV field tokenizer; depends on csvt_pkg, csvt_front,
// csvt_queue and csvt_back.
`timescale 1ns / 1ps

module csv_field_tokenizer_unit import csvt_pkg::*; #(
  parameter int unsigned TRIM_DEPTH = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 text_valid,
  output logic                 text_stall,
  input  text_item_t           text_item,
  output logic                 token_valid,
  input  logic                 token_stall,
  output token_item_t          token_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  logic [7:0] delimiter;
  logic       skip_blank_lines;
  logic       push;
  step_t      push_entry;
  logic       queue_full;
  logic       queue_avail;
  step_t      queue_head;
  logic       queue_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      delimiter        <= 8'd44;
      skip_blank_lines <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DELIMITER:  delimiter        <= cfg_data;
        REG_SKIP_BLANK: skip_blank_lines <= cfg_data[0];
        default: begin
          delimiter <= delimiter;
        end
      endcase
    end
  end

  csvt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .text_valid (text_valid),
    .text_stall (text_stall),
    .text_item  (text_item),
    .delimiter  (delimiter),
    .queue_full (queue_full),
    .push       (push),
    .entry      (push_entry)
  );

  csvt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (queue_pop),
    .full       (queue_full),
    .avail      (queue_avail),
    .head       (queue_head)
  );

  csvt_back #(
    .TRIM_DEPTH (TRIM_DEPTH)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .skip_blank_lines (skip_blank_lines),
    .avail            (queue_avail),
    .head             (queue_head),
    .pop              (queue_pop),
    .token_valid      (token_valid),
    .token_stall      (token_stall),
    .token_item       (token_item)
  );

endmodule

[hdl/csvt_front.sv]
// Front part: accepts text beats, holds back a lone carriage return and
// classifies each byte into a step for the queue. Depends on csvt_pkg.
`timescale 1ns / 1ps

module csvt_front import csvt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       text_valid,
  output logic       text_stall,
  input  text_item_t text_item,
  input  logic [7:0] delimiter,
  input  logic       queue_full,
  output logic       push,
  output step_t      entry
);

  logic held_return;
  logic held_return_next;
  logic accept;
  logic is_lf;
  logic is_cr;

  assign text_stall = queue_full;
  assign accept     = text_valid && !queue_full;
  assign is_lf      = (text_item.in_byte == CHAR_LF);
  assign is_cr      = (text_item.in_byte == CHAR_CR);

  always_comb begin
    entry.take_cr     = held_return && !is_lf;
    entry.take_byte   = !is_lf && !is_cr;
    entry.close_line  = is_lf || text_item.end_of_data;
    entry.data        = text_item.in_byte;
    entry.is_space    = (text_item.in_byte == CHAR_SPACE) ||
                        ((text_item.in_byte >= CHAR_TAB) && (text_item.in_byte <= CHAR_CR));
    entry.is_delim    = (text_item.in_byte == delimiter);
    entry.is_quote    = (text_item.in_byte == CHAR_QUOTE);
    entry.cr_is_delim = (delimiter == CHAR_CR);
  end

  // A byte with nothing to do (a first carriage return) never reaches the queue.
  assign push = accept && (entry.take_cr || entry.take_byte || entry.close_line);

  // Every line end clears the held return, so only a return that does not
  // end the text stays held.
  always_comb begin
    held_return_next = held_return;
    if (accept) begin
      held_return_next = is_cr && !text_item.end_of_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_return <= 1'b0;
    end else begin
      held_return <= held_return_next;
    end
  end

endmodule

[hdl/csvt_queue.sv]
// Short queue of classified steps between the front and back parts.
// Depends on csvt_pkg for the step type and depth.
`timescale 1ns / 1ps

module csvt_queue import csvt_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  step_t push_entry,
  input  logic  pop,
  output logic  full,
  output logic  avail,
  output step_t head
);

  localparam int unsigned QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

  step_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] wr_ptr_next;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W-1:0] rd_ptr_next;
  logic [QCNT_W-1:0] count;
  logic [QCNT_W-1:0] count_next;
  logic              do_push;
  logic              do_pop;

  assign full    = (count == QCNT_W'(QUEUE_DEPTH));
  assign avail   = (count != '0);
  assign head    = entries[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && avail;

  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    count_next  = count;
    if (do_push) begin
      wr_ptr_next = (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_next = (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_next = count + 1'b1;
    end else if (do_pop && !do_push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
    if (do_push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

endmodule

[hdl/csvt_back.sv]
// Back part: runs the field parser on queued steps, keeps trailing whitespace
// in a circular store and drives the result channel. Depends on csvt_pkg and
// the assertion macros header.
`timescale 1ns / 1ps
`include "csv_field_tokenizer_unit_macros.svh"

module csvt_back import csvt_pkg::*; #(
  parameter int unsigned TRIM_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        skip_blank_lines,
  input  logic        avail,
  input  step_t       head,
  output logic        pop,
  output logic        token_valid,
  input  logic        token_stall,
  output token_item_t token_item
);

  localparam int unsigned CNT_W = $clog2(TRIM_DEPTH + 1);
  localparam int unsigned PTR_W = (TRIM_DEPTH > 1) ? $clog2(TRIM_DEPTH) : 1;

  typedef enum logic [2:0] {
    MODE_LEAD,
    MODE_SIMPLE,
    MODE_INQ,
    MODE_QSEEN,
    MODE_POST
  } mode_t;

  typedef enum logic [1:0] {
    PH_CR,
    PH_BYTE,
    PH_CLOSE
  } phase_t;

  // Parser state
  mode_t            mode;
  mode_t            mode_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [PTR_W-1:0] head_ptr;
  logic [PTR_W-1:0] head_ptr_next;
  logic [PTR_W-1:0] tail_ptr;
  logic [PTR_W-1:0] tail_ptr_next;
  logic             field_seen;
  logic             field_seen_next;
  logic             done_cr;
  logic             done_cr_next;
  logic             done_byte;
  logic             done_byte_next;

  // Hold stage and output register
  logic             hold_valid;
  logic             hold_valid_next;
  token_item_t      hold;
  token_item_t      hold_next;
  logic             token_valid_next;
  token_item_t      token_item_next;

  // Trim store
  logic [7:0]       trim_mem [TRIM_DEPTH];
  logic [7:0]       rd_q;
  logic             byp_hit;
  logic [7:0]       byp_data;
  logic [7:0]       head_byte;
  logic             wr_en;

  // Action of the current cycle
  phase_t           cur_ph;
  logic [7:0]       x;
  logic             x_ws;
  logic             x_delim;
  logic             x_quote;
  logic             act_emit;
  logic             act_done;
  logic             step_end;
  token_item_t      gen;
  mode_t            a_mode;
  logic             a_push;
  logic             a_pop;
  logic             a_clear;
  logic             a_seen_set;
  logic             a_seen_clr;
  logic             go;
  logic             send;
  logic             out_free;

  assign head_byte = byp_hit ? byp_data : rd_q;

  // Sub-action selection: a held return first, then the byte, then line end.
  always_comb begin
    if (head.take_cr && !done_cr) begin
      cur_ph = PH_CR;
    end else if (head.take_byte && !done_byte) begin
      cur_ph = PH_BYTE;
    end else begin
      cur_ph = PH_CLOSE;
    end
    if (cur_ph == PH_CR) begin
      x       = CHAR_CR;
      x_ws    = 1'b1;
      x_delim = head.cr_is_delim;
      x_quote = 1'b0;
    end else begin
      x       = head.data;
      x_ws    = head.is_space;
      x_delim = head.is_delim;
      x_quote = head.is_quote;
    end
  end

  // One parser evaluation per cycle while go is high; act_done low means the same
  // byte is looked at again at the next evaluation (held whitespace flush,
  // re-dispatch after a closing quote, or the row mark after a closing field mark).
  always_comb begin
    act_emit   = 1'b0;
    act_done   = 1'b1;
    gen        = '{kind: KIND_BYTE, out_byte: 8'h00, trim_overflow: 1'b0, last: 1'b0};
    a_mode     = mode;
    a_push     = 1'b0;
    a_pop      = 1'b0;
    a_clear    = 1'b0;
    a_seen_set = 1'b0;
    a_seen_clr = 1'b0;
    if (cur_ph == PH_CLOSE) begin
      if (mode == MODE_SIMPLE || mode == MODE_INQ || mode == MODE_QSEEN) begin
        act_emit = 1'b1;
        gen.kind = KIND_FIELD;
        a_mode   = MODE_LEAD;
        act_done = 1'b0;
      end else begin
        act_emit   = field_seen || !skip_blank_lines;
        gen.kind   = KIND_ROW;
        a_mode     = MODE_LEAD;
        a_clear    = 1'b1;
        a_seen_clr = 1'b1;
      end
    end else begin
      a_seen_set = (cur_ph == PH_BYTE) && !x_ws;
      unique case (mode)
        MODE_LEAD: begin
          if (x_ws) begin
            a_mode = MODE_LEAD;
          end else if (x_quote) begin
            a_mode = MODE_INQ;
          end else if (x_delim) begin
            act_emit = 1'b1;
            gen.kind = KIND_FIELD;
          end else begin
            act_emit     = 1'b1;
            gen.out_byte = x;
            a_mode       = MODE_SIMPLE;
          end
        end
        MODE_SIMPLE: begin
          if (x_delim) begin
            a_clear  = 1'b1;
            act_emit = 1'b1;
            gen.kind = KIND_FIELD;
            a_mode   = MODE_LEAD;
          end else if (x_ws) begin
            a_push = 1'b1;
            if (count == CNT_W'(TRIM_DEPTH)) begin
              act_emit          = 1'b1;
              gen.out_byte      = head_byte;
              gen.trim_overflow = 1'b1;
              a_pop             = 1'b1;
            end
          end else if (count != '0) begin
            act_emit     = 1'b1;
            gen.out_byte = head_byte;
            a_pop        = 1'b1;
            act_done     = 1'b0;
          end else begin
            act_emit     = 1'b1;
            gen.out_byte = x;
          end
        end
        MODE_INQ: begin
          if (x_quote) begin
            a_mode = MODE_QSEEN;
          end else begin
            act_emit     = 1'b1;
            gen.out_byte = x;
          end
        end
        MODE_QSEEN: begin
          if (x_quote) begin
            act_emit     = 1'b1;
            gen.out_byte = CHAR_QUOTE;
            a_mode       = MODE_INQ;
          end else begin
            act_emit = 1'b1;
            gen.kind = KIND_FIELD;
            a_mode   = MODE_POST;
            act_done = x_delim;
          end
        end
        default: begin
          if (x_delim) begin
            a_mode = MODE_LEAD;
          end else if (!x_ws) begin
            a_mode   = MODE_LEAD;
            act_done = 1'b0;
          end
        end
      endcase
    end
  end

  assign step_end = act_done && ((cur_ph == PH_CLOSE) ||
                    ((cur_ph == PH_CR) && !head.take_byte && !head.close_line) ||
                    ((cur_ph == PH_BYTE) && !head.close_line));

  // The hold stage keeps the newest result until it is known whether it is
  // the last of its step; it is passed on when a later result or the end of
  // the step arrives.
  assign out_free = !token_valid || !token_stall;
  assign go   = avail && (!hold_valid || out_free ||
                (!hold.last && !act_emit && !step_end));
  assign send = hold_valid && out_free &&
                (hold.last || (go && (act_emit || step_end)));
  assign pop   = go && step_end;
  assign wr_en = go && a_push;

  always_comb begin
    mode_next       = mode;
    count_next      = count;
    head_ptr_next   = head_ptr;
    tail_ptr_next   = tail_ptr;
    field_seen_next = field_seen;
    done_cr_next    = done_cr;
    done_byte_next  = done_byte;
    hold_valid_next = hold_valid;
    hold_next       = hold;
    if (go) begin
      mode_next = a_mode;
      if (a_pop) begin
        head_ptr_next = (head_ptr == PTR_W'(TRIM_DEPTH - 1)) ? '0 : head_ptr + 1'b1;
      end
      if (a_clear) begin
        tail_ptr_next = head_ptr;
        count_next    = '0;
      end else begin
        if (a_push) begin
          tail_ptr_next = (tail_ptr == PTR_W'(TRIM_DEPTH - 1)) ? '0 : tail_ptr + 1'b1;
        end
        if (a_push && !a_pop) begin
          count_next = count + 1'b1;
        end else if (a_pop && !a_push) begin
          count_next = count - 1'b1;
        end
      end
      if (a_seen_clr) begin
        field_seen_next = 1'b0;
      end else if (a_seen_set) begin
        field_seen_next = 1'b1;
      end
      if (step_end) begin
        done_cr_next   = 1'b0;
        done_byte_next = 1'b0;
      end else if (act_done && cur_ph == PH_CR) begin
        done_cr_next = 1'b1;
      end else if (act_done && cur_ph == PH_BYTE) begin
        done_byte_next = 1'b1;
      end
    end
    if (go && act_emit) begin
      hold_valid_next = 1'b1;
      hold_next       = gen;
      hold_next.last  = step_end;
    end else if (send) begin
      hold_valid_next = 1'b0;
    end

    token_valid_next = token_valid;
    token_item_next  = token_item;
    if (send) begin
      token_valid_next     = 1'b1;
      token_item_next      = hold;
      token_item_next.last = hold.last || !act_emit;
    end else if (token_valid && !token_stall) begin
      token_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_LEAD;
      count       <= '0;
      head_ptr    <= '0;
      tail_ptr    <= '0;
      field_seen  <= 1'b0;
      done_cr     <= 1'b0;
      done_byte   <= 1'b0;
      hold_valid  <= 1'b0;
      token_valid <= 1'b0;
    end else begin
      mode        <= mode_next;
      count       <= count_next;
      head_ptr    <= head_ptr_next;
      tail_ptr    <= tail_ptr_next;
      field_seen  <= field_seen_next;
      done_cr     <= done_cr_next;
      done_byte   <= done_byte_next;
      hold_valid  <= hold_valid_next;
      token_valid <= token_valid_next;
    end
    hold       <= hold_next;
    token_item <= token_item_next;
  end

  // The read port follows the next head, so head_byte always shows the
  // oldest held byte; a write to that same entry is forwarded.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      trim_mem[tail_ptr] <= x;
    end
    rd_q     <= trim_mem[head_ptr_next];
    byp_hit  <= wr_en && (tail_ptr == head_ptr_next);
    byp_data <= x;
  end

  `CSVT_ASSERT_IMP(a_ovf_needs_full, clk, rst, go && act_emit && gen.trim_overflow, count == CNT_W'(TRIM_DEPTH), "overflow byte sent while trim store not full")
  `CSVT_ASSERT_IMP(a_empty_ptrs_meet, clk, rst, count == '0, tail_ptr == head_ptr, "empty trim store with separated pointers")
  `CSVT_ASSERT_NXT(a_line_end_clears, clk, rst, go && step_end && (cur_ph == PH_CLOSE), (field_seen == 1'b0) && (count == '0), "line end left field or trim state behind")
  `CSVT_ASSERT_IMP(a_mark_zero_byte, clk, rst, token_valid && (token_item.kind != KIND_BYTE), token_item.out_byte == 8'h00, "field or row mark carries a byte")

endmodule

[dv/csv_field_tokenizer_unit_test.sv]
// Self-checking test of csv_field_tokenizer_unit: directed and random CSV text
// against a cycle-free tokenizer model held here. Depends on csvt_pkg and the RTL.
`timescale 1ns / 1ps

module csv_field_tokenizer_unit_test;
  import csvt_pkg::*;

  localparam int unsigned TRIM_DEPTH    = 32;
  localparam int          SETTLE_CYCLES = 60;
  localparam int          DRAIN_LIMIT   = 200000;
  localparam int          PRINT_LIMIT   = 100;

  typedef enum logic [2:0] {
    P_LEAD,
    P_PLAIN,
    P_QUOTED,
    P_QUOTE_SEEN,
    P_AFTER_QUOTE
  } parse_mode_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 text_valid = 1'b0;
  logic                 text_stall;
  text_item_t           text_item = '0;
  logic                 token_valid;
  logic                 token_stall = 1'b0;
  token_item_t          token_item;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_DELIMITER;
  logic [7:0]           cfg_data = 8'h00;

  // Tokenizer model state and its copy of the registers.
  logic [7:0]  delim = 8'd44;
  logic        skip_blank = 1'b1;
  parse_mode_t mode = P_LEAD;
  logic [7:0]  trim_store [TRIM_DEPTH];
  int          trim_fill = 0;
  logic        cr_held = 1'b0;
  logic        line_has_text = 1'b0;

  token_item_t due_tokens[$];
  token_item_t want_tok;
  int          mismatches = 0;
  int          tokens_seen = 0;
  int          sent_items = 0;
  bit          quiet_sender = 1'b0;

  csv_field_tokenizer_unit #(.TRIM_DEPTH(TRIM_DEPTH)) u_top (
    .clk         (clk),
    .rst         (rst),
    .text_valid  (text_valid),
    .text_stall  (text_stall),
    .text_item   (text_item),
    .token_valid (token_valid),
    .token_stall (token_stall),
    .token_item  (token_item),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end

  // ---------------------------------------------------------------- model

  function automatic bit is_space(logic [7:0] b);
    return b == CHAR_SPACE || (b >= CHAR_TAB && b <= CHAR_CR);
  endfunction

  function automatic void push_token(logic [1:0] k, logic [7:0] b, logic ovf);
    token_item_t t;
    t = '{kind: k, out_byte: b, trim_overflow: ovf, last: 1'b0};
    due_tokens.insert(due_tokens.size(), t);
  endfunction

  function automatic void flush_trim();
    for (int i = 0; i < trim_fill; i++) push_token(KIND_BYTE, trim_store[i], 1'b0);
    trim_fill = 0;
  endfunction

  function automatic void hold_space(logic [7:0] b);
    if (trim_fill >= TRIM_DEPTH) begin
      // The buffer is full, so its oldest byte is forced out as content.
      push_token(KIND_BYTE, trim_store[0], 1'b1);
      for (int i = 0; i < TRIM_DEPTH - 1; i++) trim_store[i] = trim_store[i + 1];
      trim_fill = TRIM_DEPTH - 1;
    end
    trim_store[trim_fill] = b;
    trim_fill++;
  endfunction

  function automatic void parse_byte(logic [7:0] b);
    bit again;
    again = 1'b1;
    if (!is_space(b)) line_has_text = 1'b1;
    while (again) begin
      again = 1'b0;
      case (mode)
        P_LEAD: begin
          if (!is_space(b)) begin
            if (b == CHAR_QUOTE) begin
              mode = P_QUOTED;
            end else if (b == delim) begin
              push_token(KIND_FIELD, 8'h00, 1'b0);
            end else begin
              push_token(KIND_BYTE, b, 1'b0);
              mode = P_PLAIN;
            end
          end
        end
        P_PLAIN: begin
          if (b == delim) begin
            trim_fill = 0;
            push_token(KIND_FIELD, 8'h00, 1'b0);
            mode = P_LEAD;
          end else if (is_space(b)) begin
            hold_space(b);
          end else begin
            flush_trim();
            push_token(KIND_BYTE, b, 1'b0);
          end
        end
        P_QUOTED: begin
          if (b == CHAR_QUOTE) mode = P_QUOTE_SEEN;
          else push_token(KIND_BYTE, b, 1'b0);
        end
        P_QUOTE_SEEN: begin
          if (b == CHAR_QUOTE) begin
            push_token(KIND_BYTE, CHAR_QUOTE, 1'b0);
            mode = P_QUOTED;
          end else begin
            // The closing quote ends the field; a delimiter here is eaten and
            // the after-quote state will swallow one more.
            push_token(KIND_FIELD, 8'h00, 1'b0);
            mode = P_AFTER_QUOTE;
            if (b != delim) again = 1'b1;
          end
        end
        default: begin
          if (b == delim) begin
            mode = P_LEAD;
          end else if (!is_space(b)) begin
            mode = P_LEAD;
            again = 1'b1;
          end
        end
      endcase
    end
  endfunction

  function automatic void close_line();
    if (mode == P_PLAIN || mode == P_QUOTED || mode == P_QUOTE_SEEN)
      push_token(KIND_FIELD, 8'h00, 1'b0);
    if (line_has_text || !skip_blank) push_token(KIND_ROW, 8'h00, 1'b0);
    mode = P_LEAD;
    trim_fill = 0;
    cr_held = 1'b0;
    line_has_text = 1'b0;
  endfunction

  function automatic void tokenize_byte(logic [7:0] b, logic eod);
    int          first;
    token_item_t t;
    first = due_tokens.size();
    if (b == CHAR_LF) begin
      close_line();
    end else if (b == CHAR_CR) begin
      // Only the final carriage return before a line end is dropped.
      if (cr_held) parse_byte(CHAR_CR);
      cr_held = 1'b1;
      if (eod) close_line();
    end else begin
      if (cr_held) begin
        cr_held = 1'b0;
        parse_byte(CHAR_CR);
      end
      parse_byte(b);
      if (eod) close_line();
    end
    if (due_tokens.size() > first) begin
      t = due_tokens[due_tokens.size() - 1];
      t.last = 1'b1;
      due_tokens[due_tokens.size() - 1] = t;
    end
  endfunction

  // -------------------------------------------------------------- checking

  task automatic report_mismatch(input string what);
    // Printing is capped so that a broken build cannot flood the log.
    if (mismatches < PRINT_LIMIT) $display("MISMATCH at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (!rst && token_valid && !token_stall) begin
      if (due_tokens.size() == 0) begin
        report_mismatch($sformatf("token %0d unexpected: kind %0d byte %02h ovf %0d last %0d",
                                  tokens_seen, token_item.kind, token_item.out_byte,
                                  token_item.trim_overflow, token_item.last));
      end else begin
        want_tok = due_tokens.pop_front();
        if (token_item.kind !== want_tok.kind ||
            token_item.out_byte !== want_tok.out_byte ||
            token_item.trim_overflow !== want_tok.trim_overflow ||
            token_item.last !== want_tok.last)
          report_mismatch($sformatf(
            "token %0d: got kind %0d byte %02h ovf %0d last %0d, want %0d %02h %0d %0d",
            tokens_seen, token_item.kind, token_item.out_byte, token_item.trim_overflow,
            token_item.last, want_tok.kind, want_tok.out_byte, want_tok.trim_overflow,
            want_tok.last));
      end
      tokens_seen++;
    end
  end

  // ----------------------------------------------------------- idling

  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Output stall: long clear stretches now and then, otherwise short bursts.
  initial begin
    int run;
    int hold;
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 8);
      repeat (run) @(posedge clk);
      token_stall <= 1'b1;
      hold = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
      repeat (hold) @(posedge clk);
      token_stall <= 1'b0;
    end
  end

  // ------------------------------------------------------------ stimulus

  task automatic send_byte(input logic [7:0] b, input logic eod);
    int gap;
    gap = quiet_sender ? 0 : pick_idle();
    if (gap > 0) begin
      text_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    text_valid <= 1'b1;
    text_item  <= '{in_byte: b, end_of_data: eod};
    do @(posedge clk); while (text_stall);
    tokenize_byte(b, eod);
    sent_items++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  task automatic send_spaces(input int n);
    for (int i = 0; i < n; i++) send_byte(CHAR_SPACE, 1'b0);
  endtask

  // Pauses the text side until every predicted token has been taken.
  task automatic wait_idle();
    int waited;
    waited = 0;
    text_valid <= 1'b0;
    while (due_tokens.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (due_tokens.size() != 0) begin
      report_mismatch($sformatf("%0d tokens never arrived", due_tokens.size()));
      due_tokens.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_DELIMITER) delim = val;
    else skip_blank = val[0];
  endtask

  function automatic logic [7:0] pick_plain();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (is_space(b) || b == CHAR_QUOTE || b == CHAR_LF || b == delim);
    return b;
  endfunction

  function automatic logic [7:0] pick_quoted();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == CHAR_QUOTE || b == CHAR_LF);
    return b;
  endfunction

  function automatic logic [7:0] pick_space();
    case ($urandom_range(0, 5))
      0, 1, 2: return CHAR_SPACE;
      3: return CHAR_TAB;
      4: return 8'h0B + 8'($urandom_range(0, 1));
      default: return CHAR_CR;
    endcase
  endfunction

  task automatic send_space_run();
    int n;
    n = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 40) : $urandom_range(0, 3);
    for (int i = 0; i < n; i++) send_byte(pick_space(), 1'b0);
  endtask

  // One line of mostly well-formed CSV with random content and some noise.
  task automatic send_random_line();
    int nf;
    int len;
    nf = $urandom_range(0, 5);
    for (int f = 0; f < nf; f++) begin
      if (f > 0) send_byte(delim, 1'b0);
      if ($urandom_range(0, 3) == 0) send_space_run();
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          len = $urandom_range(1, 6);
          for (int i = 0; i < len; i++)
            send_byte(($urandom_range(0, 5) == 0 && i > 0) ? pick_space() : pick_plain(), 1'b0);
          if ($urandom_range(0, 2) == 0) send_space_run();
        end
        6, 7, 8: begin
          send_byte(CHAR_QUOTE, 1'b0);
          len = $urandom_range(0, 6);
          for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 5) == 0) begin
              send_byte(CHAR_QUOTE, 1'b0);
              send_byte(CHAR_QUOTE, 1'b0);
            end else begin
              send_byte(pick_quoted(), 1'b0);
            end
          end
          if ($urandom_range(0, 7) != 0) send_byte(CHAR_QUOTE, 1'b0);
          if ($urandom_range(0, 3) == 0) send_space_run();
          if ($urandom_range(0, 5) == 0) send_byte(pick_plain(), 1'b0);
        end
        default: begin
          len = $urandom_range(1, 4);
          for (int i = 0; i < len; i++) send_byte(8'($urandom_range(0, 255)), 1'b0);
        end
      endcase
    end
    if ($urandom_range(0, 4) == 0) send_space_run();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: send_byte(CHAR_LF, 1'b0);
      5, 6: begin
        send_byte(CHAR_CR, 1'b0);
        send_byte(CHAR_LF, 1'b0);
      end
      7: send_byte(CHAR_LF, 1'b1);
      8: send_byte(8'($urandom_range(0, 255)), 1'b1);
      default: begin
        send_byte(CHAR_CR, 1'b0);
        send_byte(CHAR_CR, 1'b0);
        send_byte(CHAR_LF, 1'($urandom_range(0, 1)));
      end
    endcase
  endtask

  task automatic send_random_lines(input int n);
    int stop_at;
    stop_at = sent_items + n;
    while (sent_items < stop_at) send_random_line();
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_directed_text();
    // Doubled quote, delimiter after a closing quote, trailing delimiter and
    // two carriage returns before the newline.
    send_text("\"a\"\"b\" , ,c,");
    send_byte(CHAR_CR, 1'b0);
    send_byte(CHAR_CR, 1'b0);
    send_byte(CHAR_LF, 1'b0);
    // Text straight after a closing quote, top-half bytes and end of data.
    send_text("\"u\"v ");
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h00, 1'b1);
    // A blank line, then a quote left open at the line end.
    send_text("  \n");
    send_text("\"w\n");
  endtask

  task automatic test_trim_overflow();
    send_text("ab");
    send_spaces(40);
    send_text("c\n");
    send_text("x");
    send_spaces(TRIM_DEPTH);
    send_text("y");
    send_spaces(TRIM_DEPTH + 1);
    send_text(",q");
    send_spaces(TRIM_DEPTH + 3);
    send_text("\n");
    send_random_lines(15);
  endtask

  task automatic test_blank_rows();
    write_reg(REG_SKIP_BLANK, 8'h00);
    send_text(" \t\n\n");
    send_byte(CHAR_CR, 1'b0);
    send_byte(CHAR_LF, 1'b0);
    send_random_lines(20);
    write_reg(REG_SKIP_BLANK, 8'h01);
    send_text(" \n\n");
    send_random_lines(15);
  endtask

  task automatic run_delimiter_phase(input logic [7:0] d, input logic skip, input int n);
    write_reg(REG_DELIMITER, d);
    write_reg(REG_SKIP_BLANK, {7'd0, skip});
    send_random_lines(n);
  endtask

  task automatic test_delimiter_range();
    run_delimiter_phase(8'h00, 1'b1, 15);
    run_delimiter_phase(8'hFF, 1'b0, 15);
    run_delimiter_phase(CHAR_SPACE, 1'b1, 12);
    run_delimiter_phase(CHAR_TAB, 1'b0, 12);
    run_delimiter_phase(CHAR_QUOTE, 1'b1, 12);
    run_delimiter_phase(CHAR_CR, 1'b0, 12);
    run_delimiter_phase(CHAR_LF, 1'b1, 12);
    run_delimiter_phase(8'h3B, 1'b0, 12);
    run_delimiter_phase(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 12);
  endtask

  task automatic test_drain_pause();
    run_delimiter_phase(8'd44, 1'b1, 0);
    quiet_sender = 1'b1;
    send_random_lines(15);
    quiet_sender = 1'b0;
    // Hold the text side off until the output has fully caught up.
    wait_idle();
    send_random_lines(15);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_directed_text();
    send_random_lines(15);
    test_trim_overflow();
    test_blank_rows();
    test_delimiter_range();
    test_drain_pause();
    wait_idle();
    if (mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
